// ===== sv/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types, character codes and code tables of the Morse codec.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

  typedef struct packed {
    logic [7:0] symbol_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // key of one code: symbol count, then symbols with the first one highest
  typedef struct packed {
    logic [2:0] len;
    logic [5:0] bits;
  } code_t;

  // work handed from the front end to the back end
  typedef struct packed {
    logic       is_code;
    logic [7:0] ch;
    code_t      code;
    logic [7:0] sep;
  } job_t;

  typedef struct packed {
    logic       hit;
    code_t      code;
  } enc_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } dec_t;

  localparam logic       REG_DIRECTION = 1'b0;
  localparam logic       REG_SEPARATOR = 1'b1;

  localparam logic       DIR_DECODE    = 1'b0;
  localparam logic       DIR_ENCODE    = 1'b1;

  localparam logic [7:0] SEP_RESET     = 8'h20;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_OPEN       = 8'h28;
  localparam logic [7:0] CH_CLOSE      = 8'h29;

  localparam logic [2:0] LEN_MAX       = 3'd6;
  localparam logic [2:0] LEN_BAD       = 3'd7;
  localparam code_t      PAREN_CODE    = '{len: 3'd6, bits: 6'b101101};

  function automatic enc_t encode_char(input logic [7:0] ch);
    enc_t r;
    r.hit = 1'b1;
    case (ch)
      "a":     r.code = '{3'd2, 6'b000001};
      "b":     r.code = '{3'd4, 6'b001000};
      "c":     r.code = '{3'd4, 6'b001010};
      "d":     r.code = '{3'd3, 6'b000100};
      "e":     r.code = '{3'd1, 6'b000000};
      "f":     r.code = '{3'd4, 6'b000010};
      "g":     r.code = '{3'd3, 6'b000110};
      "h":     r.code = '{3'd4, 6'b000000};
      "i":     r.code = '{3'd2, 6'b000000};
      "j":     r.code = '{3'd4, 6'b000111};
      "k":     r.code = '{3'd3, 6'b000101};
      "l":     r.code = '{3'd4, 6'b000100};
      "m":     r.code = '{3'd2, 6'b000011};
      "n":     r.code = '{3'd2, 6'b000010};
      "o":     r.code = '{3'd3, 6'b000111};
      "p":     r.code = '{3'd4, 6'b000110};
      "q":     r.code = '{3'd4, 6'b001101};
      "r":     r.code = '{3'd3, 6'b000010};
      "s":     r.code = '{3'd3, 6'b000000};
      "t":     r.code = '{3'd1, 6'b000001};
      "u":     r.code = '{3'd3, 6'b000001};
      "v":     r.code = '{3'd4, 6'b000001};
      "w":     r.code = '{3'd3, 6'b000011};
      "x":     r.code = '{3'd4, 6'b001001};
      "y":     r.code = '{3'd4, 6'b001011};
      "z":     r.code = '{3'd4, 6'b001100};
      "1":     r.code = '{3'd5, 6'b001111};
      "2":     r.code = '{3'd5, 6'b000111};
      "3":     r.code = '{3'd5, 6'b000011};
      "4":     r.code = '{3'd5, 6'b000001};
      "5":     r.code = '{3'd5, 6'b000000};
      "6":     r.code = '{3'd5, 6'b010000};
      "7":     r.code = '{3'd5, 6'b011000};
      "8":     r.code = '{3'd5, 6'b011100};
      "9":     r.code = '{3'd5, 6'b011110};
      "0":     r.code = '{3'd5, 6'b011111};
      "?":     r.code = '{3'd6, 6'b001100};
      "/":     r.code = '{3'd5, 6'b010010};
      "-":     r.code = '{3'd6, 6'b100001};
      ".":     r.code = '{3'd6, 6'b010101};
      "(":     r.code = PAREN_CODE;
      ")":     r.code = PAREN_CODE;
      default: begin
        r.hit  = 1'b0;
        r.code = '{3'd0, 6'b000000};
      end
    endcase
    return r;
  endfunction

  function automatic dec_t decode_code(input code_t code);
    dec_t r;
    r.hit = 1'b1;
    case ({code.len, code.bits})
      {3'd2, 6'b000001}: r.ch = "a";
      {3'd4, 6'b001000}: r.ch = "b";
      {3'd4, 6'b001010}: r.ch = "c";
      {3'd3, 6'b000100}: r.ch = "d";
      {3'd1, 6'b000000}: r.ch = "e";
      {3'd4, 6'b000010}: r.ch = "f";
      {3'd3, 6'b000110}: r.ch = "g";
      {3'd4, 6'b000000}: r.ch = "h";
      {3'd2, 6'b000000}: r.ch = "i";
      {3'd4, 6'b000111}: r.ch = "j";
      {3'd3, 6'b000101}: r.ch = "k";
      {3'd4, 6'b000100}: r.ch = "l";
      {3'd2, 6'b000011}: r.ch = "m";
      {3'd2, 6'b000010}: r.ch = "n";
      {3'd3, 6'b000111}: r.ch = "o";
      {3'd4, 6'b000110}: r.ch = "p";
      {3'd4, 6'b001101}: r.ch = "q";
      {3'd3, 6'b000010}: r.ch = "r";
      {3'd3, 6'b000000}: r.ch = "s";
      {3'd1, 6'b000001}: r.ch = "t";
      {3'd3, 6'b000001}: r.ch = "u";
      {3'd4, 6'b000001}: r.ch = "v";
      {3'd3, 6'b000011}: r.ch = "w";
      {3'd4, 6'b001001}: r.ch = "x";
      {3'd4, 6'b001011}: r.ch = "y";
      {3'd4, 6'b001100}: r.ch = "z";
      {3'd5, 6'b001111}: r.ch = "1";
      {3'd5, 6'b000111}: r.ch = "2";
      {3'd5, 6'b000011}: r.ch = "3";
      {3'd5, 6'b000001}: r.ch = "4";
      {3'd5, 6'b000000}: r.ch = "5";
      {3'd5, 6'b010000}: r.ch = "6";
      {3'd5, 6'b011000}: r.ch = "7";
      {3'd5, 6'b011100}: r.ch = "8";
      {3'd5, 6'b011110}: r.ch = "9";
      {3'd5, 6'b011111}: r.ch = "0";
      {3'd6, 6'b001100}: r.ch = "?";
      {3'd5, 6'b010010}: r.ch = "/";
      {3'd6, 6'b100001}: r.ch = "-";
      {3'd6, 6'b010101}: r.ch = ".";
      default: begin
        r.hit = 1'b0;
        r.ch  = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mcc_front.sv =====
// ----------------------------------------------------------------------------
// mcc_front
// Accepts requests, holds the configuration and the decode token state, and
// turns each request into at most one job for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [7:0]       cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mcc_pkg::in_item_t in_data,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output mcc_pkg::job_t         job_data
);

  logic          direction;
  logic [7:0]    separator;
  mcc_pkg::code_t token;
  mcc_pkg::code_t token_next;
  logic          paren_open;
  logic          paren_open_next;

  logic          is_sep;
  logic          is_sym;
  logic          do_flush;
  logic          is_paren;
  logic          accept;
  mcc_pkg::code_t upd;
  mcc_pkg::code_t flush_code;
  mcc_pkg::dec_t  dec;
  mcc_pkg::enc_t  enc;
  logic          has_job;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_sep = (in_data.symbol_byte == separator);
    is_sym = (in_data.symbol_byte == mcc_pkg::CH_DOT) ||
             (in_data.symbol_byte == mcc_pkg::CH_DASH);

    // token after this byte, before any flush
    upd = token;
    if (is_sym && (token.len < mcc_pkg::LEN_MAX)) begin
      upd.len  = token.len + 3'd1;
      upd.bits = {token.bits[4:0], (in_data.symbol_byte == mcc_pkg::CH_DASH)};
    end else begin
      upd.len = mcc_pkg::LEN_BAD;
    end

    do_flush   = is_sep || in_data.end_of_message;
    flush_code = is_sep ? token : upd;
    is_paren   = (flush_code == mcc_pkg::PAREN_CODE);
    dec        = mcc_pkg::decode_code(flush_code);
    enc        = mcc_pkg::encode_char(in_data.symbol_byte);

    token_next      = do_flush ? '0 : upd;
    paren_open_next = paren_open ^ (do_flush && is_paren);

    job_data.sep  = separator;
    job_data.code = enc.code;
    if (direction == mcc_pkg::DIR_ENCODE) begin
      has_job          = enc.hit;
      job_data.is_code = 1'b1;
      job_data.ch      = in_data.symbol_byte;
    end else begin
      has_job          = do_flush && (is_paren || dec.hit);
      job_data.is_code = 1'b0;
      job_data.ch      = is_paren ? (paren_open ? mcc_pkg::CH_CLOSE : mcc_pkg::CH_OPEN)
                                  : dec.ch;
    end
  end

  assign job_valid = in_valid && has_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= mcc_pkg::DIR_DECODE;
      separator  <= mcc_pkg::SEP_RESET;
      token      <= '{3'd0, 6'd0};
      paren_open <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mcc_pkg::REG_DIRECTION: direction <= cfg_wdata[0];
          mcc_pkg::REG_SEPARATOR: separator <= cfg_wdata;
          default:                separator <= separator;
        endcase
      end
      if (accept && (direction == mcc_pkg::DIR_DECODE)) begin
        token      <= token_next;
        paren_open <= paren_open_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/mcc_queue.sv =====
// ----------------------------------------------------------------------------
// mcc_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire mcc_pkg::job_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output mcc_pkg::job_t      pop_data
);

  mcc_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/mcc_back.sv =====
// ----------------------------------------------------------------------------
// mcc_back
// Expands jobs into result bytes into a registered output, one a cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire mcc_pkg::job_t job_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mcc_pkg::out_item_t out_data
);

  logic               busy;
  mcc_pkg::job_t      job;
  logic [2:0]         idx;
  logic               slot_free;
  logic               finishing;
  logic [2:0]         pos;
  mcc_pkg::out_item_t cur;

  always_comb begin
    pos = job.code.len - 3'd1 - idx;
    if (!job.is_code) begin
      cur.out_byte = job.ch;
      cur.run_last = 1'b1;
    end else if (idx == job.code.len) begin
      cur.out_byte = job.sep;
      cur.run_last = 1'b1;
    end else begin
      cur.out_byte = job.code.bits[pos] ? mcc_pkg::CH_DASH : mcc_pkg::CH_DOT;
      cur.run_last = 1'b0;
    end
  end

  assign slot_free = !out_valid || out_ready;
  assign finishing = busy && slot_free && cur.run_last;
  assign job_ready = !busy || finishing;

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_data <= cur;
    end
    if (job_valid && job_ready) begin
      job <= job_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid <= busy;
      end
      if (job_valid && job_ready) begin
        busy <= 1'b1;
        idx  <= 3'd0;
      end else if (busy && slot_free) begin
        if (cur.run_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/morse_code_codec_top.sv =====
// ----------------------------------------------------------------------------
// morse_code_codec_top
// Morse codec over a byte stream: decodes dots and dashes into characters or
// encodes characters into dots, dashes and a separator.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   in_data   (symbol_byte, end_of_message)
//   out      out_valid / out_ready out_data  (out_byte, run_last)
//   cfg      cfg_we                cfg_index, cfg_wdata
//
// a request is taken when the job queue has room; the back end emits one byte
// a cycle while the output is not stalled. a decode request yields at most one
// byte and an encode request up to seven (code symbols plus separator).
// a two-entry job queue and the output register let either side stall alone.
// synchronous reset clears direction to decode, separator to space, the token
// and the parenthesis state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_code_codec_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mcc_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mcc_pkg::out_item_t      out_data
);

  logic          fq_valid;
  logic          fq_ready;
  mcc_pkg::job_t fq_data;
  logic          qb_valid;
  logic          qb_ready;
  mcc_pkg::job_t qb_data;

  mcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job_data  (fq_data)
  );

  mcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  mcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
